>>> rtl/core/rtd_pkg.sv
`default_nettype none

package rtd_pkg;

	localparam int unsigned TABLE_DEPTH_DEF   = 256;
	localparam int unsigned FRACTION_BITS_DEF = 8;

	localparam int unsigned READING_W  = 24;
	localparam int unsigned TEMP_W     = 16;
	localparam int unsigned ENTRY_IDX_W = 8;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [TEMP_W-1:0] OUT_OF_RANGE_CODE = 16'hffff;
	localparam logic [TEMP_W-1:0] SATURATED_CODE    = 16'hfffe;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd2;

	localparam logic [READING_W-1:0] LOW_LIMIT_RST      = 24'h000000;
	localparam logic [READING_W-1:0] HIGH_LIMIT_RST     = 24'hffffff;
	localparam logic [COUNT_W-1:0]   ENTRIES_IN_USE_RST = 9'd256;

	// action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_CONVERT = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/rtd_table_search_interpolate.sv
`default_nettype none

// Sensor reading to temperature converter with a loadable rising lookup table.
// Command channel: an item is taken at a clock edge with start high and busy low.
//   action = load writes entry_value at entry_index into the table; busy stays
//   low and no result follows, so the next item may come in the next cycle.
//   action = convert checks sample_value against low_limit/high_limit; an
//   out-of-range sample gives its result in the next cycle without going busy.
//   An in-range sample is binary-searched in the table (each probe reads one
//   entry in S_SEARCH and compares it in S_CMP). Unless the search hits an
//   entry exactly or the sample lies below the first or above the last entry,
//   one read of the neighbouring entry follows, then, for a sample strictly
//   inside a rising bracket, a restoring divider that yields one fraction bit
//   per cycle. done rises in the same cycle that busy falls.
// Result channel: done is high for exactly one cycle with temperature and
// out_of_range; the receiver cannot stall it.
// Configuration: cfg_write with cfg_index/cfg_data writes a limit register or
// the entry count; the user must do so only while the block is idle, as the
// block does not enforce it. Reset clears the control state and sets the
// registers to their defaults; table contents are undefined until loaded.
module rtd_table_search_interpolate #(
	parameter int unsigned TABLE_DEPTH   = rtd_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned FRACTION_BITS = rtd_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              action,
	input  wire logic [rtd_pkg::ENTRY_IDX_W-1:0]   entry_index,
	input  wire logic [rtd_pkg::READING_W-1:0]     entry_value,
	input  wire logic [rtd_pkg::READING_W-1:0]     sample_value,
	output logic                                   done,
	output logic [rtd_pkg::TEMP_W-1:0]             temperature,
	output logic                                   out_of_range,
	input  wire logic                              cfg_write,
	input  wire logic [rtd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rtd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import rtd_pkg::*;

	localparam int unsigned IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned NW   = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
	localparam int unsigned AW   = ((IW > ENTRY_IDX_W) ? IW : ENTRY_IDX_W) + 1;
	localparam int unsigned TW   = (IW + FRACTION_BITS > TEMP_W + 1) ?
		IW + FRACTION_BITS : TEMP_W + 1;
	localparam int unsigned CNTW = $clog2(FRACTION_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_FIX,
		S_NEIGH,
		S_DIV,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [READING_W-1:0]   low_limit_q;
	logic [READING_W-1:0]   high_limit_q;
	logic [COUNT_W-1:0]     entries_q;

	logic [READING_W-1:0]   table_mem [TABLE_DEPTH];
	logic [READING_W-1:0]   rd_data_q;

	logic [READING_W-1:0]   sample_q;
	logic [IW:0]            lo_q;
	logic [IW:0]            hi_q;
	logic [IW-1:0]          last_q;
	logic [IW-1:0]          mid_q;
	logic [READING_W-1:0]   dat_q;
	logic [IW-1:0]          idx_q;
	logic                   nb_lower_q;
	logic [READING_W-1:0]   rem_q;
	logic [READING_W-1:0]   div_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [CNTW-1:0]        cnt_q;

	logic                   accept;
	logic                   mem_we;
	logic                   mem_re;
	logic [IW-1:0]          mem_ra;
	logic [IW-1:0]          mem_wa;
	logic [NW-1:0]          ent_w;
	logic [NW-1:0]          n_w;
	logic [IW+1:0]          sum_w;
	logic [IW-1:0]          mid_w;
	logic                   sample_oor;
	logic [READING_W-1:0]   lower_w;
	logic [READING_W-1:0]   upper_w;
	logic [READING_W:0]     rem2_w;
	logic                   qbit_w;
	logic [TW-1:0]          t_w;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	assign sample_oor = (sample_value > high_limit_q) || (sample_value < low_limit_q);
	assign mem_wa     = IW'(AW'(entry_index));
	assign mem_we     = accept && (action == ACT_LOAD) &&
		(AW'(entry_index) < AW'(TABLE_DEPTH));

	// clamp the entry count to 2..TABLE_DEPTH
	always_comb begin
		ent_w = NW'(entries_q);
		if (ent_w < NW'(2)) begin
			n_w = NW'(2);
		end else if (ent_w > NW'(TABLE_DEPTH)) begin
			n_w = NW'(TABLE_DEPTH);
		end else begin
			n_w = ent_w;
		end
	end

	assign sum_w = (IW+2)'(lo_q) + (IW+2)'(hi_q);
	assign mid_w = sum_w[IW:1];

	// table read address: probe during the search, neighbour afterwards
	always_comb begin
		mem_re = 1'b0;
		mem_ra = mid_w;
		if (state_q == S_SEARCH) begin
			mem_re = (lo_q <= hi_q);
		end else if (state_q == S_FIX) begin
			mem_re = 1'b1;
			if (dat_q > sample_q) begin
				mem_ra = mid_q - IW'(1);
			end else begin
				mem_ra = mid_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= entry_value;
		end
		if (mem_re) begin
			rd_data_q <= table_mem[mem_ra];
		end
	end

	assign lower_w = nb_lower_q ? rd_data_q : dat_q;
	assign upper_w = nb_lower_q ? dat_q : rd_data_q;

	// one restoring division step
	assign rem2_w = {rem_q, 1'b0};
	assign qbit_w = (rem2_w >= {1'b0, div_q});

	assign t_w = TW'({idx_q, frac_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RST;
			high_limit_q <= HIGH_LIMIT_RST;
			entries_q    <= ENTRIES_IN_USE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LOW_LIMIT:      low_limit_q  <= cfg_data[READING_W-1:0];
				REG_HIGH_LIMIT:     high_limit_q <= cfg_data[READING_W-1:0];
				REG_ENTRIES_IN_USE: entries_q    <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done         <= 1'b0;
			temperature  <= '0;
			out_of_range <= 1'b0;
			sample_q     <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			last_q       <= '0;
			mid_q        <= '0;
			dat_q        <= '0;
			idx_q        <= '0;
			nb_lower_q   <= 1'b0;
			rem_q        <= '0;
			div_q        <= '0;
			frac_q       <= '0;
			cnt_q        <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (action == ACT_CONVERT)) begin
						if (sample_oor) begin
							done         <= 1'b1;
							temperature  <= OUT_OF_RANGE_CODE;
							out_of_range <= 1'b1;
						end else begin
							sample_q <= sample_value;
							lo_q     <= '0;
							hi_q     <= (IW+1)'(n_w - NW'(1));
							last_q   <= IW'(n_w - NW'(1));
							state_q  <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (lo_q <= hi_q) begin
						mid_q   <= mid_w;
						state_q <= S_CMP;
					end else begin
						state_q <= S_FIX;
					end
				end
				S_CMP: begin
					dat_q <= rd_data_q;
					if (sample_q > rd_data_q) begin
						lo_q    <= (IW+1)'(mid_q) + (IW+1)'(1);
						state_q <= S_SEARCH;
					end else if (sample_q < rd_data_q) begin
						if (mid_q == '0) begin
							state_q <= S_FIX;
						end else begin
							hi_q    <= (IW+1)'(mid_q) - (IW+1)'(1);
							state_q <= S_SEARCH;
						end
					end else begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					frac_q <= '0;
					if (dat_q == sample_q) begin
						idx_q   <= mid_q;
						state_q <= S_OUT;
					end else if (dat_q > sample_q) begin
						// probe entry is the upper bracket
						if (mid_q == '0) begin
							idx_q   <= '0;
							state_q <= S_OUT;
						end else begin
							idx_q      <= mid_q - IW'(1);
							nb_lower_q <= 1'b1;
							state_q    <= S_NEIGH;
						end
					end else begin
						// probe entry is the lower bracket
						if (mid_q >= last_q) begin
							idx_q   <= last_q;
							state_q <= S_OUT;
						end else begin
							idx_q      <= mid_q;
							nb_lower_q <= 1'b0;
							state_q    <= S_NEIGH;
						end
					end
				end
				S_NEIGH: begin
					if ((upper_w <= lower_w) || (sample_q <= lower_w)) begin
						frac_q  <= '0;
						state_q <= S_OUT;
					end else if (sample_q >= upper_w) begin
						frac_q  <= '1;
						state_q <= S_OUT;
					end else begin
						rem_q   <= sample_q - lower_w;
						div_q   <= upper_w - lower_w;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (qbit_w) begin
						rem_q <= READING_W'(rem2_w - {1'b0, div_q});
					end else begin
						rem_q <= READING_W'(rem2_w);
					end
					frac_q <= FRACTION_BITS'({frac_q, qbit_w});
					cnt_q  <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(FRACTION_BITS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done         <= 1'b1;
					out_of_range <= 1'b0;
					if (t_w >= TW'(OUT_OF_RANGE_CODE)) begin
						temperature <= SATURATED_CODE;
					end else begin
						temperature <= t_w[TEMP_W-1:0];
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> verif/rtd_table_search_interpolate_tb.sv
module rtd_table_search_interpolate_tb;
	import rtd_pkg::*;

	localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
	localparam int unsigned FRAC_BITS     = FRACTION_BITS_DEF;
	localparam int unsigned ITEM_TARGET   = 1750;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned END_WAIT      = 600;
	localparam int unsigned QUIET_LIMIT   = 1000;

	localparam logic [READING_W-1:0] MAX_READING = '1;
	// index with no register behind it, writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic              oor;
	} conversion_t;

	typedef enum logic [1:0] {ROW_LOAD, ROW_CONVERT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [ENTRY_IDX_W-1:0] index;
		logic [READING_W-1:0]   value;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic                   typed;
		conversion_t            want;
	} directed_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   start        = 1'b0;
	logic                   busy;
	logic                   action       = ACT_LOAD;
	logic [ENTRY_IDX_W-1:0] entry_index  = '0;
	logic [READING_W-1:0]   entry_value  = '0;
	logic [READING_W-1:0]   sample_value = '0;
	logic                   done;
	logic [TEMP_W-1:0]      temperature;
	logic                   out_of_range;
	logic                   cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	logic [READING_W-1:0] readings [DEPTH];
	logic [READING_W-1:0] cfg_low     = LOW_LIMIT_RST;
	logic [READING_W-1:0] cfg_high    = HIGH_LIMIT_RST;
	logic [COUNT_W-1:0]   cfg_entries = ENTRIES_IN_USE_RST;

	conversion_t pending_results [$];
	int unsigned mismatches   = 0;
	int unsigned items_sent   = 0;
	int unsigned burst_left   = 0;
	int unsigned quiet_cycles = 0;

	always #6 clk = ~clk;

	rtd_table_search_interpolate u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.sample_value (sample_value),
		.done         (done),
		.temperature  (temperature),
		.out_of_range (out_of_range),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic int unsigned entries_searched();
		if (cfg_entries < 2) return 2;
		if (cfg_entries > DEPTH) return DEPTH;
		return 32'(cfg_entries);
	endfunction

	function automatic longint unsigned bracket_fraction(logic [READING_W-1:0] lower,
			logic [READING_W-1:0] upper, logic [READING_W-1:0] smp);
		longint unsigned top;
		longint unsigned q;
		top = (64'd1 << FRAC_BITS) - 64'd1;
		if (upper <= lower || smp <= lower) return 0;
		if (smp >= upper) return top;
		q = (64'(smp - lower) << FRAC_BITS) / 64'(upper - lower);
		return (q > top) ? top : q;
	endfunction

	function automatic conversion_t predict_conversion(logic [READING_W-1:0] smp);
		conversion_t       r;
		int unsigned       n;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		int unsigned       idx;
		logic [READING_W-1:0] probe;
		longint unsigned   frac;
		longint unsigned   t;
		r.oor = 1'b0;
		if (smp > cfg_high || smp < cfg_low) begin
			r.temp = OUT_OF_RANGE_CODE;
			r.oor  = 1'b1;
			return r;
		end
		n     = entries_searched();
		lo    = 0;
		hi    = n - 1;
		mid   = 0;
		probe = '0;
		frac  = 0;
		while (lo <= hi) begin
			mid   = (lo + hi) >> 1;
			probe = readings[mid];
			if (smp > probe) begin
				lo = mid + 1;
			end else if (smp < probe) begin
				if (mid == 0) break;
				hi = mid - 1;
			end else begin
				break;
			end
		end
		if (probe == smp) begin
			idx = mid;
		end else if (probe > smp) begin
			if (mid == 0) begin
				idx = 0;
			end else begin
				idx  = mid - 1;
				frac = bracket_fraction(readings[mid-1], readings[mid], smp);
			end
		end else begin
			if (mid >= n - 1) begin
				idx = n - 1;
			end else begin
				idx  = mid;
				frac = bracket_fraction(readings[mid], readings[mid+1], smp);
			end
		end
		t = (64'(idx) << FRAC_BITS) + frac;
		if (t >= 64'(OUT_OF_RANGE_CODE)) t = 64'(SATURATED_CODE);
		r.temp = t[TEMP_W-1:0];
		return r;
	endfunction

	function automatic directed_row_t load_row(logic [ENTRY_IDX_W-1:0] idx,
			logic [READING_W-1:0] val);
		directed_row_t r;
		r       = '0;
		r.kind  = ROW_LOAD;
		r.index = idx;
		r.value = val;
		return r;
	endfunction

	function automatic directed_row_t conv_row(logic [READING_W-1:0] smp);
		directed_row_t r;
		r       = '0;
		r.kind  = ROW_CONVERT;
		r.value = smp;
		return r;
	endfunction

	function automatic directed_row_t conv_known(logic [READING_W-1:0] smp,
			logic [TEMP_W-1:0] temp, logic oor);
		directed_row_t r;
		r           = '0;
		r.kind      = ROW_CONVERT;
		r.value     = smp;
		r.typed     = 1'b1;
		r.want.temp = temp;
		r.want.oor  = oor;
		return r;
	endfunction

	function automatic directed_row_t reg_row(logic [CFG_IDX_W-1:0] ridx,
			logic [READING_W-1:0] data);
		directed_row_t r;
		r           = '0;
		r.kind      = ROW_REG;
		r.reg_index = ridx;
		r.value     = data;
		return r;
	endfunction

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	// sender works in bursts, a random gap opens each new burst
	task automatic issue_item(logic act, logic [ENTRY_IDX_W-1:0] idx,
			logic [READING_W-1:0] eval, logic [READING_W-1:0] smp,
			logic typed, conversion_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4: gap = 0;
				5, 6, 7:       gap = $urandom_range(4, 1);
				8:             gap = $urandom_range(20, 5);
				default:       gap = $urandom_range(45, 21);
			endcase
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start        <= 1'b1;
		action       <= act;
		entry_index  <= idx;
		entry_value  <= eval;
		sample_value <= smp;
		do @(posedge clk); while (busy);
		// beat taken at this edge
		items_sent++;
		if (act == ACT_LOAD) readings[idx] = eval;
		else pending_results.push_back(typed ? want : predict_conversion(smp));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// loads leave nothing to wait for, so give the engine its full latency
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] ridx, logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_write <= 1'b1;
		cfg_index <= ridx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (ridx)
			REG_LOW_LIMIT:      cfg_low     = data;
			REG_HIGH_LIMIT:     cfg_high    = data;
			REG_ENTRIES_IN_USE: cfg_entries = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic fill_rising(int unsigned count, int unsigned first,
			int unsigned step_lo, int unsigned step_hi);
		int unsigned v;
		int unsigned i;
		v = first;
		for (i = 0; i < count; i++) begin
			issue_item(ACT_LOAD, 8'(i), 24'(v), 24'($urandom), 1'b0, '0);
			v += $urandom_range(step_hi, step_lo);
		end
	endtask

	always @(posedge clk) begin
		conversion_t oldest;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending",
						64'({temperature, out_of_range}), 64'(0));
			end else begin
				oldest = pending_results.pop_front();
				if (temperature !== oldest.temp)
					flag_mismatch("temperature", 64'(temperature), 64'(oldest.temp));
				if (out_of_range !== oldest.oor)
					flag_mismatch("out_of_range", 64'(out_of_range), 64'(oldest.oor));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("** rtd_table_search_interpolate: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		directed_row_t        directed [$];
		conversion_t          none;
		int unsigned          span;
		int unsigned          maxstep;
		int unsigned          pos;
		int unsigned          n_conv;
		logic [READING_W-1:0] smp;
		logic [READING_W-1:0] a;
		logic [READING_W-1:0] b;

		none = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// entry i reads 1000 + 100*i
		fill_rising(DEPTH, 1000, 100, 100);

		directed.push_back(conv_known(24'd0, 16'h0000, 1'b0));
		directed.push_back(conv_known(MAX_READING, 16'hff00, 1'b0));
		directed.push_back(conv_known(24'd1000, 16'h0000, 1'b0));
		directed.push_back(conv_known(24'd26500, 16'hff00, 1'b0));
		directed.push_back(conv_known(24'd13800, 16'h8000, 1'b0));
		directed.push_back(conv_row(24'd1050));
		directed.push_back(load_row(8'd255, MAX_READING));
		directed.push_back(conv_known(MAX_READING, 16'hff00, 1'b0));
		directed.push_back(conv_row(24'hfffffe));
		directed.push_back(load_row(8'd0, 24'd0));
		directed.push_back(conv_known(24'd0, 16'h0000, 1'b0));
		directed.push_back(reg_row(REG_LOW_LIMIT, 24'd500));
		directed.push_back(conv_known(24'd499, OUT_OF_RANGE_CODE, 1'b1));
		directed.push_back(reg_row(REG_HIGH_LIMIT, 24'd20000));
		directed.push_back(conv_known(24'd20001, OUT_OF_RANGE_CODE, 1'b1));
		directed.push_back(conv_row(24'd20000));
		// crossed limits reject everything
		directed.push_back(reg_row(REG_LOW_LIMIT, 24'h800000));
		directed.push_back(reg_row(REG_HIGH_LIMIT, 24'h7fffff));
		directed.push_back(conv_known(24'h800000, OUT_OF_RANGE_CODE, 1'b1));
		directed.push_back(conv_known(24'h7fffff, OUT_OF_RANGE_CODE, 1'b1));
		directed.push_back(reg_row(REG_LOW_LIMIT, LOW_LIMIT_RST));
		directed.push_back(reg_row(REG_HIGH_LIMIT, HIGH_LIMIT_RST));
		directed.push_back(reg_row(REG_SPARE, MAX_READING));
		// entry count clamps at both ends
		directed.push_back(reg_row(REG_ENTRIES_IN_USE, 24'd2));
		directed.push_back(conv_known(MAX_READING, 16'h0100, 1'b0));
		directed.push_back(reg_row(REG_ENTRIES_IN_USE, 24'd0));
		directed.push_back(conv_known(MAX_READING, 16'h0100, 1'b0));
		directed.push_back(reg_row(REG_ENTRIES_IN_USE, 24'h1ff));
		directed.push_back(conv_known(MAX_READING, 16'hff00, 1'b0));
		// flat bracket, then a dip in the table
		directed.push_back(load_row(8'd2, 24'd1100));
		directed.push_back(conv_row(24'd1100));
		directed.push_back(load_row(8'd3, 24'd500));
		directed.push_back(conv_row(24'd1250));

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_REG: write_register(directed[i].reg_index, directed[i].value);
				ROW_LOAD: issue_item(ACT_LOAD, directed[i].index, directed[i].value,
						24'($urandom), 1'b0, none);
				default: issue_item(ACT_CONVERT, 8'($urandom), 24'($urandom),
						directed[i].value, directed[i].typed, directed[i].want);
			endcase
		end

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(1, 0) == 1) begin
				case ($urandom_range(9, 0))
					0:       pos = DEPTH;
					1:       pos = $urandom_range(1, 0);
					2:       pos = $urandom_range(511, 257);
					3:       pos = 2;
					default: pos = $urandom_range(48, 3);
				endcase
				// bits above the count field are junk and must be dropped
				write_register(REG_ENTRIES_IN_USE, {15'($urandom), 9'(pos)});
			end
			span = entries_searched();

			// a fresh rising table over the searched span, steps may be zero
			if ((span < DEPTH) ? ($urandom_range(3, 0) != 0) : ($urandom_range(3, 0) == 0)) begin
				case ($urandom_range(3, 0))
					0:       maxstep = 3;
					1:       maxstep = 300;
					2:       maxstep = 20000;
					default: maxstep = 32'hffffff / span;
				endcase
				fill_rising(span, $urandom_range(32'hffffff - span * maxstep, 0), 0, maxstep);
			end

			if ($urandom_range(1, 0) == 1) begin
				case ($urandom_range(7, 0))
					4: begin
						a = readings[$urandom_range(span - 1, 0)];
						b = readings[$urandom_range(span - 1, 0)];
						write_register(REG_LOW_LIMIT, (a < b) ? a : b);
						write_register(REG_HIGH_LIMIT, (a < b) ? b : a);
					end
					5: begin
						a = 24'($urandom_range(32'hfffffe, 0));
						write_register(REG_HIGH_LIMIT, a);
						write_register(REG_LOW_LIMIT, 24'($urandom_range(32'hffffff, a + 1)));
					end
					6: write_register(REG_SPARE, 24'($urandom));
					7: begin
						a = 24'($urandom);
						write_register(REG_LOW_LIMIT, a);
						write_register(REG_HIGH_LIMIT, 24'($urandom_range(32'hffffff, a)));
					end
					default: begin
						write_register(REG_LOW_LIMIT, LOW_LIMIT_RST);
						write_register(REG_HIGH_LIMIT, HIGH_LIMIT_RST);
					end
				endcase
			end

			n_conv = $urandom_range(50, 20);
			repeat (n_conv) begin
				// stray load anywhere in the table
				if ($urandom_range(11, 0) == 0)
					issue_item(ACT_LOAD, 8'($urandom), 24'($urandom), 24'($urandom), 1'b0, none);
				case ($urandom_range(7, 0))
					0: smp = readings[$urandom_range(span - 1, 0)];
					1, 2: begin
						pos = $urandom_range(span - 2, 0);
						a   = readings[pos];
						b   = readings[pos + 1];
						smp = (b > a) ? 24'(a + $urandom_range(b - a, 0)) : a;
					end
					3: smp = (readings[0] == 0) ? '0 : 24'($urandom_range(readings[0] - 1, 0));
					4: begin
						a   = readings[span - 1];
						smp = (a == MAX_READING) ? a : 24'($urandom_range(32'hffffff, a + 1));
					end
					5: begin
						case ($urandom_range(3, 0))
							0:       smp = cfg_low;
							1:       smp = 24'(cfg_low - 24'd1);
							2:       smp = cfg_high;
							default: smp = 24'(cfg_high + 24'd1);
						endcase
					end
					6:       smp = 24'($urandom);
					default: smp = ($urandom_range(1, 0) == 1) ? MAX_READING : '0;
				endcase
				issue_item(ACT_CONVERT, 8'($urandom), 24'($urandom), smp, 1'b0, none);
			end

			if ($urandom_range(4, 0) == 0) drain_results();
		end

		start <= 1'b0;
		for (pos = 0; pos < END_WAIT && pending_results.size() != 0; pos++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never delivered", 64'(pending_results.size()), 64'(0));
		if (mismatches == 0) begin
			$display("** rtd_table_search_interpolate: PASSED **");
		end else begin
			$display("** rtd_table_search_interpolate: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rtd_pkg.sv
rtl/core/rtd_table_search_interpolate.sv
verif/rtd_table_search_interpolate_tb.sv
